FILE: hw/rtl/lookahead_peak_limiter_unit_macros.svh
// ----------------------------------------------------------------------------
// lookahead peak limiter assertion macros
// shared property forms for the checker, clocked on clk, held off in reset
// ----------------------------------------------------------------------------
`ifndef LOOKAHEAD_PEAK_LIMITER_UNIT_MACROS_SVH
`define LOOKAHEAD_PEAK_LIMITER_UNIT_MACROS_SVH

// same-cycle implication
`define LPL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/lpl_pkg.sv
// ----------------------------------------------------------------------------
// lookahead peak limiter package
// shared types, register codes, reset values and gain constants
// ----------------------------------------------------------------------------
package lpl_pkg;

	localparam int CHANNELS = 2;
	localparam int CHW      = $clog2(CHANNELS);
	localparam int SW       = 24;
	localparam int GW       = 24;
	localparam int LW       = 11;
	localparam int IDXW     = 2;
	localparam int MW       = 25;
	localparam int DCW      = 5;

	localparam logic [GW-1:0]  UNITY_GAIN = 24'd8388608;
	localparam logic [GW-1:0]  LIMIT_MARK = 24'd8387769;
	localparam logic [GW-1:0]  CEIL_RST   = 24'd8388608;
	localparam logic [GW-1:0]  COEFF_RST  = 24'd16773721;
	localparam logic [LW-1:0]  LEN_RST    = 11'd240;
	localparam logic [DCW-1:0] DIV_STEPS  = 5'd23;

	typedef enum logic [IDXW-1:0] {
		REG_CEILING   = 2'd0,
		REG_RELEASE   = 2'd1,
		REG_LOOKAHEAD = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PEAK,
		ST_CMP,
		ST_DIV,
		ST_ENV,
		ST_REL,
		ST_MUL,
		ST_ACC,
		ST_FIN
	} state_t;

	typedef logic signed [SW-1:0] sample_t;
	typedef sample_t [CHANNELS-1:0] frame_t;

	typedef struct packed {
		logic          start;
		logic [GW-1:0] num;
		logic [GW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [GW-1:0] quot;
	} div_rsp_t;

endpackage

FILE: hw/rtl/lookahead_peak_limiter_unit.sv
// ----------------------------------------------------------------------------
// lookahead peak limiter
// one frame at a time: the next request is taken only once the block is back in idle;
//   the 23-step divider runs only when the peak exceeds the ceiling, and a result still
//   waiting at the output holds the block back
// reset: gain to unity, registers to defaults, delay line reads as silence at once
// ----------------------------------------------------------------------------
module lookahead_peak_limiter_unit #(
	parameter int LOOKAHEAD_MAX = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [23:0]          sample_ch0,
	input  logic signed [23:0]          sample_ch1,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [23:0]          out_ch0,
	output logic signed [23:0]          out_ch1,
	output logic                        limited,
	output logic [23:0]                 applied_gain,
	input  logic                        cfg_wen,
	input  logic [lpl_pkg::IDXW-1:0]    cfg_idx,
	input  logic [23:0]                 cfg_wdata
);

	localparam int PW = $clog2(LOOKAHEAD_MAX);
	localparam int FW = PW + 1;
	localparam int CW = (FW > lpl_pkg::LW) ? FW : lpl_pkg::LW;
	localparam logic [FW-1:0] MAX_F  = FW'(LOOKAHEAD_MAX);
	localparam logic [CW-1:0] MAX_C  = CW'(LOOKAHEAD_MAX);
	localparam logic [PW-1:0] LAST_P = PW'(LOOKAHEAD_MAX - 1);

	lpl_pkg::state_t            state_q, state_d;

	logic [lpl_pkg::GW-1:0]     ceiling_q;
	logic [lpl_pkg::GW-1:0]     coeff_q;
	logic [lpl_pkg::LW-1:0]     len_q;

	lpl_pkg::frame_t            smp_q;
	lpl_pkg::frame_t            rd_q;
	lpl_pkg::frame_t            res_q;
	lpl_pkg::frame_t            mem [LOOKAHEAD_MAX];
	logic [lpl_pkg::GW-1:0]     peak_q;
	logic [lpl_pkg::GW-1:0]     target_q;
	logic [lpl_pkg::GW-1:0]     env_q;
	logic [PW-1:0]              wp_q;
	logic [FW-1:0]              fill_q;
	logic                       hit_q;
	logic                       zero_q;
	logic [lpl_pkg::CHW-1:0]    ch_q;
	logic signed [2*lpl_pkg::MW-1:0] prod_q;

	logic                       out_valid_q;
	logic signed [23:0]         out_ch0_q;
	logic signed [23:0]         out_ch1_q;
	logic                       limited_q;
	logic [lpl_pkg::GW-1:0]     gain_q;

	logic [lpl_pkg::GW-1:0]     mag   [lpl_pkg::CHANNELS];
	logic [lpl_pkg::GW-1:0]     peak_d;
	logic [CW-1:0]              len_ext;
	logic [FW-1:0]              lenc;
	logic [FW-1:0]              rd_full;
	logic [PW-1:0]              rd_addr;
	lpl_pkg::sample_t           dsel;
	logic signed [lpl_pkg::MW-1:0] mul_a;
	logic signed [lpl_pkg::MW-1:0] mul_b;
	logic                       mul_en;
	logic                       mem_we;
	logic                       mem_re;
	logic                       fire;
	logic                       ch_last;
	lpl_pkg::div_req_t          div_req;
	lpl_pkg::div_rsp_t          div_rsp;

	lpl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// peak magnitude over the captured frame
	always_comb begin
		logic signed [lpl_pkg::SW:0] sx;
		logic signed [lpl_pkg::SW:0] neg;
		peak_d = '0;
		for (int c = 0; c < lpl_pkg::CHANNELS; c++) begin
			sx     = (lpl_pkg::SW+1)'($signed(smp_q[c]));
			neg    = -sx;
			mag[c] = sx[lpl_pkg::SW] ? neg[lpl_pkg::SW-1:0] : sx[lpl_pkg::SW-1:0];
			if (mag[c] > peak_d) begin
				peak_d = mag[c];
			end
		end
	end

	// clamped length and read address
	always_comb begin
		len_ext = CW'(len_q);
		lenc    = (len_ext > MAX_C) ? MAX_F : FW'(len_ext);
		if ({1'b0, wp_q} >= lenc) begin
			rd_full = {1'b0, wp_q} - lenc;
		end else begin
			rd_full = {1'b0, wp_q} + MAX_F - lenc;
		end
		rd_addr = rd_full[PW-1:0];
	end

	assign dsel    = zero_q ? smp_q[ch_q] : (hit_q ? rd_q[ch_q] : '0);
	assign fire    = !out_valid_q || out_ready;
	assign ch_last = ch_q == lpl_pkg::CHW'(lpl_pkg::CHANNELS - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			lpl_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = lpl_pkg::ST_PEAK;
				end
			end
			lpl_pkg::ST_PEAK: state_d = lpl_pkg::ST_CMP;
			lpl_pkg::ST_CMP: begin
				state_d = (peak_q > ceiling_q) ? lpl_pkg::ST_DIV : lpl_pkg::ST_ENV;
			end
			lpl_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = lpl_pkg::ST_ENV;
				end
			end
			lpl_pkg::ST_ENV: begin
				state_d = (target_q < env_q) ? lpl_pkg::ST_MUL : lpl_pkg::ST_REL;
			end
			lpl_pkg::ST_REL: state_d = lpl_pkg::ST_MUL;
			lpl_pkg::ST_MUL: state_d = lpl_pkg::ST_ACC;
			lpl_pkg::ST_ACC: state_d = ch_last ? lpl_pkg::ST_FIN : lpl_pkg::ST_MUL;
			lpl_pkg::ST_FIN: begin
				if (fire) begin
					state_d = lpl_pkg::ST_IDLE;
				end
			end
			default: state_d = lpl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		mem_re        = 1'b0;
		mem_we        = 1'b0;
		mul_en        = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		div_req.start = 1'b0;
		div_req.num   = ceiling_q;
		div_req.den   = peak_q;
		case (state_q)
			lpl_pkg::ST_IDLE: in_ready = 1'b1;
			lpl_pkg::ST_PEAK: mem_re = 1'b1;
			lpl_pkg::ST_CMP: begin
				mem_we        = 1'b1;
				div_req.start = peak_q > ceiling_q;
			end
			lpl_pkg::ST_ENV: begin
				mul_en = 1'b1;
				mul_a  = {1'b0, coeff_q};
				mul_b  = {1'b0, lpl_pkg::UNITY_GAIN - env_q};
			end
			lpl_pkg::ST_MUL: begin
				mul_en = 1'b1;
				mul_a  = lpl_pkg::MW'($signed(dsel));
				mul_b  = {1'b0, env_q};
			end
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= lpl_pkg::CEIL_RST;
			coeff_q   <= lpl_pkg::COEFF_RST;
			len_q     <= lpl_pkg::LEN_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				lpl_pkg::REG_CEILING:   ceiling_q <= cfg_wdata;
				lpl_pkg::REG_RELEASE:   coeff_q   <= cfg_wdata;
				lpl_pkg::REG_LOOKAHEAD: len_q     <= cfg_wdata[lpl_pkg::LW-1:0];
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpl_pkg::ST_IDLE;
			env_q       <= lpl_pkg::UNITY_GAIN;
			wp_q        <= '0;
			fill_q      <= '0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wen && cfg_idx == lpl_pkg::REG_LOOKAHEAD) begin
				wp_q   <= '0;
				fill_q <= '0;
			end else if (mem_we) begin
				wp_q <= (wp_q == LAST_P) ? '0 : wp_q + 1'b1;
				if (fill_q != MAX_F) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (state_q == lpl_pkg::ST_ENV && target_q < env_q) begin
				env_q <= target_q;
			end else if (state_q == lpl_pkg::ST_REL) begin
				env_q <= lpl_pkg::UNITY_GAIN - prod_q[2*lpl_pkg::GW-1:lpl_pkg::GW];
			end
			if (state_q == lpl_pkg::ST_CMP) begin
				ch_q <= '0;
			end else if (state_q == lpl_pkg::ST_ACC && !ch_last) begin
				ch_q <= ch_q + 1'b1;
			end
			if (state_q == lpl_pkg::ST_FIN && fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			smp_q[0] <= sample_ch0;
			smp_q[1] <= sample_ch1;
		end
		if (state_q == lpl_pkg::ST_PEAK) begin
			peak_q <= peak_d;
			hit_q  <= fill_q >= lenc;
			zero_q <= lenc == '0;
		end
		if (state_q == lpl_pkg::ST_CMP) begin
			target_q <= lpl_pkg::UNITY_GAIN;
		end else if (state_q == lpl_pkg::ST_DIV && div_rsp.done) begin
			target_q <= div_rsp.quot;
		end
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == lpl_pkg::ST_ACC) begin
			res_q[ch_q] <= prod_q[lpl_pkg::SW+22:23];
		end
		if (state_q == lpl_pkg::ST_FIN && fire) begin
			out_ch0_q <= res_q[0];
			out_ch1_q <= res_q[1];
			limited_q <= env_q <= lpl_pkg::LIMIT_MARK;
			gain_q    <= env_q;
		end
	end

	// delay line
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q] <= smp_q;
		end
		if (mem_re) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign out_valid    = out_valid_q;
	assign out_ch0      = out_ch0_q;
	assign out_ch1      = out_ch1_q;
	assign limited      = limited_q;
	assign applied_gain = gain_q;

endmodule

FILE: hw/rtl/lpl_div.sv
// ----------------------------------------------------------------------------
// lookahead peak limiter gain divider
// restoring divider, one quotient bit per cycle: floor(num * 2^23 / den), num < den
// ----------------------------------------------------------------------------
module lpl_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lpl_pkg::div_req_t req,
	output lpl_pkg::div_rsp_t rsp
);

	logic                     busy_q;
	logic                     done_q;
	logic [lpl_pkg::DCW-1:0]  cnt_q;
	logic [lpl_pkg::GW-1:0]   rem_q;
	logic [lpl_pkg::GW-1:0]   den_q;
	logic [lpl_pkg::GW-1:0]   quot_q;
	logic [lpl_pkg::GW:0]     rem_dbl;
	logic [lpl_pkg::GW:0]     rem_sub;
	logic                     take;

	assign rem_dbl = {rem_q, 1'b0};
	assign take    = rem_dbl >= {1'b0, den_q};
	assign rem_sub = take ? (rem_dbl - {1'b0, den_q}) : rem_dbl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= lpl_pkg::DIV_STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == lpl_pkg::DCW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= rem_sub[lpl_pkg::GW-1:0];
			quot_q <= {quot_q[lpl_pkg::GW-2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

FILE: hw/rtl/lpl_chk.sv
// ----------------------------------------------------------------------------
// lookahead peak limiter port checker
// watches the top level ports over time; bound to every instance
// ----------------------------------------------------------------------------
`include "lookahead_peak_limiter_unit_macros.svh"

module lpl_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] out_ch0,
	input logic [23:0] out_ch1,
	input logic        limited,
	input logic [23:0] applied_gain
);

	`LPL_ASSERT_IMP(a_gain_range, out_valid, applied_gain <= lpl_pkg::UNITY_GAIN, "gain above unity")
	`LPL_ASSERT_IMP(a_limited_flag, out_valid, limited == (applied_gain <= lpl_pkg::LIMIT_MARK), "limited flag does not match gain")
	`LPL_ASSERT_NXT(a_one_request, in_valid && in_ready, !in_ready, "second request taken while busy")
	`LPL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_ch0) && $stable(out_ch1) && $stable(limited) && $stable(applied_gain), "stalled result changed")

endmodule

bind lookahead_peak_limiter_unit lpl_chk u_lpl_chk (.*);

FILE: verif/limiter_checker.sv
// ----------------------------------------------------------------------------
// lookahead peak limiter checker
// watches the request, result and register ports of the limiter, keeps its
// own copy of the gain envelope, delay line and registers, works out the
// result of every accepted request and compares it field by field with what
// the block delivers
// ----------------------------------------------------------------------------
module limiter_checker #(
	parameter int LOOKAHEAD_MAX = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  lpl_pkg::sample_t         sample_ch0,
	input  lpl_pkg::sample_t         sample_ch1,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  lpl_pkg::sample_t         out_ch0,
	input  lpl_pkg::sample_t         out_ch1,
	input  logic                     limited,
	input  logic [23:0]              applied_gain,
	input  logic                     cfg_wen,
	input  logic [lpl_pkg::IDXW-1:0] cfg_idx,
	input  logic [23:0]              cfg_wdata,
	output int                       errors,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import lpl_pkg::*;

	localparam int FRAC      = 23;
	localparam int EXP_DEPTH = 16;

	typedef struct packed {
		sample_t       ch0;
		sample_t       ch1;
		logic          limited;
		logic [GW-1:0] gain;
	} limiter_out_t;

	limiter_out_t  exp_mem [EXP_DEPTH];
	int            exp_head  = 0;
	int            exp_tail  = 0;
	int            exp_count = 0;
	int            err_count = 0;
	logic [GW-1:0] ceiling_q;
	logic [GW-1:0] release_q;
	logic [LW-1:0] lookahead_q;
	logic [GW-1:0] envelope;
	frame_t        delay_mem [LOOKAHEAD_MAX];
	int            wr_ptr;

	assign errors  = err_count;
	assign pending = exp_count;

	function automatic void clear_delay();
		for (int i = 0; i < LOOKAHEAD_MAX; i++) begin
			delay_mem[i] = '0;
		end
		wr_ptr = 0;
	endfunction

	// floor of sample times gain over full scale
	function automatic sample_t scale(input sample_t s, input logic [GW-1:0] g);
		logic signed [SW+GW:0] p;
		p = $signed(s) * $signed({1'b0, g});
		return sample_t'(p >>> FRAC);
	endfunction

	function automatic limiter_out_t limit_frame(input sample_t a, input sample_t b);
		frame_t                fresh;
		frame_t                delayed;
		logic signed [SW:0]    wide;
		logic [SW:0]           mag;
		logic [SW:0]           peak;
		logic [GW-1:0]         target;
		logic [2*GW-1:0]       shrink;
		int                    span;
		limiter_out_t          r;
		fresh[0] = a;
		fresh[1] = b;
		peak = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			wide = $signed(fresh[c]);
			mag  = (wide < 0) ? -wide : wide;
			if (mag > peak)
				peak = mag;
		end
		if (peak > {1'b0, ceiling_q})
			target = GW'({ceiling_q, 23'd0} / peak);
		else
			target = UNITY_GAIN;
		// instant attack, smoothed release toward unity
		if (target < envelope) begin
			envelope = target;
		end else begin
			shrink   = release_q * (UNITY_GAIN - envelope);
			envelope = UNITY_GAIN - shrink[2*GW-1:GW];
		end
		span = (lookahead_q > LOOKAHEAD_MAX) ? LOOKAHEAD_MAX : int'(lookahead_q);
		if (span == 0)
			delayed = fresh;
		else
			delayed = delay_mem[(wr_ptr + LOOKAHEAD_MAX - span) % LOOKAHEAD_MAX];
		delay_mem[wr_ptr] = fresh;
		wr_ptr = (wr_ptr + 1) % LOOKAHEAD_MAX;
		r.ch0     = scale(delayed[0], envelope);
		r.ch1     = scale(delayed[1], envelope);
		r.limited = (envelope <= LIMIT_MARK);
		r.gain    = envelope;
		return r;
	endfunction

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			err_count++;
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		limiter_out_t got;
		limiter_out_t want;
		if (!arst_n) begin
			ceiling_q   = CEIL_RST;
			release_q   = COEFF_RST;
			lookahead_q = LEN_RST;
			envelope    = UNITY_GAIN;
			clear_delay();
			exp_head  = 0;
			exp_tail  = 0;
			exp_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{out_ch0, out_ch1, limited, applied_gain};
				if (exp_count == 0) begin
					err_count++;
					$display("%0t: result with no request waiting, expected none actual %0d %0d %0d %0d",
						$time, got.ch0, got.ch1, got.limited, got.gain);
				end else begin
					want      = exp_mem[exp_head];
					exp_head  = (exp_head + 1) % EXP_DEPTH;
					exp_count = exp_count - 1;
					check_field("out_ch0", int'(want.ch0), int'(got.ch0));
					check_field("out_ch1", int'(want.ch1), int'(got.ch1));
					check_field("limited", int'(want.limited), int'(got.limited));
					check_field("applied_gain", int'(want.gain), int'(got.gain));
				end
			end
			if (cfg_wen) begin
				case (cfg_idx)
					REG_CEILING: ceiling_q = cfg_wdata;
					REG_RELEASE: release_q = cfg_wdata;
					REG_LOOKAHEAD: begin
						lookahead_q = cfg_wdata[LW-1:0];
						clear_delay();
					end
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (exp_count == EXP_DEPTH) begin
					err_count++;
					$display("%0t: requests in flight, expected at most %0d actual %0d",
						$time, EXP_DEPTH, exp_count + 1);
				end else begin
					exp_mem[exp_tail] = limit_frame(sample_ch0, sample_ch1);
					exp_tail  = (exp_tail + 1) % EXP_DEPTH;
					exp_count = exp_count + 1;
				end
			end
		end
	end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// lookahead peak limiter testbench
// drives stereo requests in random bursts against a randomly stalling
// receiver, steps the registers through their extremes between idle phases,
// and leaves prediction and comparison to the checker beside the block
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lpl_pkg::*;

	localparam int LOOKAHEAD_MAX = 1024;
	localparam int STALL_LIMIT   = 20000;
	localparam int TAIL_CYCLES   = 60;
	localparam int PHASES        = 12;
	localparam logic [IDXW-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_TOGGLE
	} rx_mode_t;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	sample_t         sample_ch0;
	sample_t         sample_ch1;
	logic            out_valid;
	logic            out_ready = 1'b0;
	sample_t         out_ch0;
	sample_t         out_ch1;
	logic            limited;
	logic [GW-1:0]   applied_gain;
	logic            cfg_wen;
	logic [IDXW-1:0] cfg_idx;
	logic [GW-1:0]   cfg_wdata;
	int              errors;
	int              pending;
	int              idle_cycles = 0;
	int              burst_left = 0;
	int              ready_span = 0;
	rx_mode_t        ready_mode = RX_OPEN;
	logic [GW-1:0]   cur_ceiling = CEIL_RST;

	always #5 clk = ~clk;

	lookahead_peak_limiter_unit #(
		.LOOKAHEAD_MAX(LOOKAHEAD_MAX)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_ch0  (sample_ch0),
		.sample_ch1  (sample_ch1),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_ch0     (out_ch0),
		.out_ch1     (out_ch1),
		.limited     (limited),
		.applied_gain(applied_gain),
		.cfg_wen     (cfg_wen),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata)
	);

	limiter_checker #(
		.LOOKAHEAD_MAX(LOOKAHEAD_MAX)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample_ch0  (sample_ch0),
		.sample_ch1  (sample_ch1),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_ch0     (out_ch0),
		.out_ch1     (out_ch1),
		.limited     (limited),
		.applied_gain(applied_gain),
		.cfg_wen     (cfg_wen),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.errors      (errors),
		.pending     (pending)
	);

	// receiver stall pattern, mode changes every so often
	always @(posedge clk) begin
		if (ready_span == 0) begin
			ready_mode <= rx_mode_t'($urandom_range(0, 3));
			ready_span <= $urandom_range(16, 200);
		end else begin
			ready_span <= ready_span - 1;
		end
		case (ready_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= ($urandom_range(0, 1) == 0);
			RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
			default:   out_ready <= ~out_ready;
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send_frame(input sample_t a, input sample_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 5);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		sample_ch0 <= a;
		sample_ch1 <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
	endtask

	// sender holds off until every result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDXW-1:0] idx, input logic [GW-1:0] value);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		@(posedge clk);
		if (idx == REG_CEILING)
			cur_ceiling = value;
	endtask

	function automatic sample_t pick_sample();
		int   mag;
		logic neg;
		neg = $urandom_range(0, 1);
		case ($urandom_range(0, 9))
			0:       mag = 8388608;
			1:       mag = $urandom_range(0, 2000);
			2, 3:    mag = int'(cur_ceiling) + int'($urandom_range(0, 4000)) - 2000;
			default: mag = $urandom_range(0, 8388608);
		endcase
		if (mag < 0)
			mag = 0;
		if (mag > 8388608)
			mag = 8388608;
		if (!neg && mag == 8388608)
			mag = 8388607;
		return sample_t'(neg ? -mag : mag);
	endfunction

	initial begin
		int            phase_items;
		int            quiet_left;
		logic [GW-1:0] cfg_val;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		sample_ch0 = '0;
		sample_ch1 = '0;
		cfg_wen    = 1'b0;
		cfg_idx    = '0;
		cfg_wdata  = '0;
		quiet_left = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings, long delay so only silence comes out
		send_frame(24'sh7fffff, 24'sh800000);
		send_frame(0, 0);
		send_frame(24'sh800000, 24'sh7fffff);
		wait_drained();

		// zero lookahead, half-scale ceiling, instant release
		write_reg(REG_LOOKAHEAD, 24'd0);
		write_reg(REG_CEILING, 24'd4194304);
		write_reg(REG_RELEASE, 24'd0);
		send_frame(1, -1);
		send_frame(-1, 1);
		send_frame(24'sh7fffff, 0);
		send_frame(0, 24'sh800000);
		send_frame(24'sd4194304, -24'sd4194305);
		send_frame(0, 0);
		send_frame(24'sd123456, -24'sd654321);
		wait_drained();

		// ceiling zero, slowest release
		write_reg(REG_CEILING, 24'd0);
		write_reg(REG_RELEASE, 24'hffffff);
		write_reg(REG_LOOKAHEAD, 24'd3);
		send_frame(5, -7);
		send_frame(0, 0);
		send_frame(-1, 0);
		send_frame(24'sh7fffff, 24'sh7fffff);
		send_frame(0, 0);
		wait_drained();

		// ceiling above full scale, same lookahead rewritten, stray index ignored
		write_reg(REG_CEILING, 24'hffffff);
		write_reg(REG_LOOKAHEAD, 24'd3);
		write_reg(REG_UNUSED, 24'd1);
		send_frame(24'sh800000, 24'sh800000);
		send_frame(24'sh7fffff, 0);
		send_frame(0, 0);
		send_frame(1, 1);
		wait_drained();

		// lookahead past the end of the line, then exactly the full line
		write_reg(REG_LOOKAHEAD, 24'd2047);
		write_reg(REG_CEILING, 24'd1);
		send_frame(24'sh800000, 1);
		send_frame(2, -2);
		wait_drained();
		write_reg(REG_LOOKAHEAD, 24'd1024);
		send_frame(3, 4);
		send_frame(-24'sd8388607, 24'sd9);
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 7))
					0:       cfg_val = 24'd1;
					1:       cfg_val = UNITY_GAIN;
					2:       cfg_val = 24'hffffff;
					3:       cfg_val = 24'd0;
					default: cfg_val = $urandom_range(1000000, 8388608);
				endcase
				write_reg(REG_CEILING, cfg_val);
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0:       cfg_val = 24'd0;
					1:       cfg_val = 24'hffffff;
					2:       cfg_val = COEFF_RST;
					3:       cfg_val = $urandom_range(0, 24'hffffff);
					default: cfg_val = $urandom_range(15000000, 24'hffffff);
				endcase
				write_reg(REG_RELEASE, cfg_val);
			end
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 7))
					0:       cfg_val = 24'd240;
					1:       cfg_val = 24'd1024;
					2:       cfg_val = $urandom_range(1025, 2047);
					3:       cfg_val = $urandom_range(0, 1024);
					default: cfg_val = $urandom_range(0, 12);
				endcase
				write_reg(REG_LOOKAHEAD, cfg_val);
			end
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, $urandom_range(0, 24'hffffff));
			phase_items = $urandom_range(120, 210);
			for (int n = 0; n < phase_items; n++) begin
				// quiet stretches let the envelope release
				if (quiet_left == 0 && $urandom_range(0, 31) == 0)
					quiet_left = $urandom_range(10, 60);
				if (quiet_left != 0) begin
					quiet_left--;
					send_frame(sample_t'(int'($urandom_range(0, 200)) - 100),
						sample_t'(int'($urandom_range(0, 200)) - 100));
				end else begin
					send_frame(pick_sample(), pick_sample());
				end
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
